// File: rtl/brsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and field widths of the road shortest-path core.
package brsp_pkg;

  localparam int NODE_W  = 4;
  localparam int WIN_W   = 8;
  localparam int TIME_W  = 12;
  localparam int STAT_W  = 3;
  localparam int MAX_RES = 16;
  localparam int RES_W   = 5;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_BLOCK   = 2'd1;
  localparam logic [1:0] MODE_UNBLOCK = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  localparam logic [STAT_W-1:0] ST_PATH       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_PATH    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ADDED      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BLOCK_DONE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_ROAD    = 3'd4;

  localparam logic [TIME_W-1:0] TIME_MAX = 12'hFFF;

  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [WIN_W-1:0]  weight;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] total_time;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_BLOCK,
    CMD_UNBLOCK,
    CMD_QUERY,
    CMD_NO_ROAD,
    CMD_NO_PATH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WIN_W-1:0]  w;
  } cmd_t;

endpackage

// File: rtl/brsp_front.sv
`timescale 1ns / 1ps
// Input side: accept items and classify them into commands for the back end.
module brsp_front #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  brsp_pkg::in_item_t in_item,
  input  logic               in_push,
  output logic               in_full,
  input  logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output brsp_pkg::cmd_t     q_cmd
);
  import brsp_pkg::*;

  logic [WIN_W-1:0] wmask;
  logic [WIN_W-1:0] wm;
  logic             bad_node;

  assign wmask    = WIN_W'((32'd1 << WEIGHT_BITS) - 32'd1);
  assign wm       = in_item.weight & wmask;
  assign bad_node = (32'(in_item.from_node) >= NODES) || (32'(in_item.to_node) >= NODES);

  assign in_full = q_full | busy;
  assign q_push  = in_push & ~in_full;

  always_comb begin
    q_cmd.a = in_item.from_node;
    q_cmd.b = in_item.to_node;
    q_cmd.w = wm;
    case (in_item.mode)
      MODE_ADD:     q_cmd.op = (bad_node || wm == '0) ? CMD_NO_ROAD : CMD_ADD;
      MODE_BLOCK:   q_cmd.op = bad_node ? CMD_NO_ROAD : CMD_BLOCK;
      MODE_UNBLOCK: q_cmd.op = bad_node ? CMD_NO_ROAD : CMD_UNBLOCK;
      MODE_QUERY:   q_cmd.op = bad_node ? CMD_NO_PATH : CMD_QUERY;
      default:      q_cmd.op = CMD_NO_ROAD;
    endcase
  end

endmodule

// File: rtl/brsp_cmdq.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front and back ends.
module brsp_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  brsp_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output brsp_pkg::cmd_t dout,
  output logic           empty
);
  import brsp_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = slot_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/brsp_back.sv
`timescale 1ns / 1ps
// Back end: road table, Dijkstra sequencer, path walk and result register.
module brsp_back #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brsp_pkg::cmd_t      q_cmd,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                clearing,
  output brsp_pkg::out_item_t out_item,
  output logic                out_empty,
  input  logic                out_pop
);
  import brsp_pkg::*;

  localparam int NB = $clog2(NODES);
  localparam int AW = 2 * NB;
  localparam int RD = 1 << AW;
  localparam int DW = WEIGHT_BITS + NB + 1;
  localparam int PD = NODES + 1;
  localparam int PB = $clog2(PD);
  localparam int CW = $clog2(PD + 1);
  localparam int IW = NB + 1;

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b0000000001,
    S_IDLE      = 10'b0000000010,
    S_RMW       = 10'b0000000100,
    S_RESP      = 10'b0000001000,
    S_SCAN      = 10'b0000010000,
    S_RELAX     = 10'b0000100000,
    S_WALK      = 10'b0001000000,
    S_WALK_WAIT = 10'b0010000000,
    S_E_RD      = 10'b0100000000,
    S_E_OUT     = 10'b1000000000
  } state_t;

  function automatic logic [AW-1:0] road_key(input logic [NB-1:0] x, input logic [NB-1:0] y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r;
  cmd_t              cmd_r;
  logic [STAT_W-1:0] resp_r;
  logic [IW-1:0]     idx_r;
  logic              pv_r;
  logic [NB-1:0]     pidx_r;
  logic              found_r;
  logic [DW-1:0]     best_d_r;
  logic [NB-1:0]     best_i_r;
  logic [NB-1:0]     u_r;
  logic [DW-1:0]     du_r;
  logic [NB-1:0]     src_r, dst_r;
  logic [NODES-1:0]  reached_r, fin_r;
  logic [CW-1:0]     cnt_r;
  logic [NB-1:0]     walk_v_r;
  logic [RES_W-1:0]  k_r, n_r;
  logic [DW-1:0]     tot_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [WEIGHT_BITS:0]   road_mem [RD];
  logic [WEIGHT_BITS:0]   road_rd_r;
  logic [DW-1:0]          dist_mem [NODES];
  logic [DW-1:0]          dist_rd_r;
  logic [NB-1:0]          pred_mem [NODES];
  logic [NB-1:0]          pred_rd_r;
  logic [NB-1:0]          path_mem [PD];
  logic [NB-1:0]          path_rd_r;

  logic                   road_we;
  logic [AW-1:0]          road_wa, road_ra;
  logic [WEIGHT_BITS:0]   road_wd;
  logic                   dist_we;
  logic [NB-1:0]          dist_wa, dist_ra;
  logic [DW-1:0]          dist_wd;
  logic                   pred_we;
  logic                   path_we;
  logic [PB-1:0]          path_wa, path_ra;
  logic [NB-1:0]          path_wd;

  logic                   slot_free;
  logic                   issue;
  logic [NB-1:0]          i_idx;
  logic                   sweep_done;
  logic                   cand;
  logic [WEIGHT_BITS-1:0] rw;
  logic                   rblk;
  logic [DW-1:0]          nd;
  logic                   relax_upd;
  logic [NB-1:0]          q_src;
  logic [AW-1:0]          q_key;
  logic                   walk_end;
  logic                   e_last;
  logic [TIME_W-1:0]      tot_sat;
  logic                   emit;
  out_item_t              emit_item;

  assign slot_free  = ~out_valid_r | out_pop;
  assign issue      = (32'(idx_r) < NODES);
  assign i_idx      = idx_r[NB-1:0];
  assign sweep_done = ~issue & ~pv_r;
  assign cand       = pv_r && reached_r[pidx_r] && !fin_r[pidx_r] &&
                      (!found_r || dist_rd_r < best_d_r);
  assign rw         = road_rd_r[WEIGHT_BITS-1:0];
  assign rblk       = road_rd_r[WEIGHT_BITS];
  assign nd         = du_r + DW'(rw);
  assign relax_upd  = pv_r && rw != '0 && !rblk && !fin_r[pidx_r] &&
                      (!reached_r[pidx_r] || nd < dist_rd_r);
  assign q_src      = NB'(q_cmd.a);
  assign q_key      = road_key(NB'(q_cmd.a), NB'(q_cmd.b));
  assign walk_end   = (walk_v_r == src_r) || (32'(cnt_r) == NODES);
  assign e_last     = (k_r == n_r - RES_W'(1));
  assign tot_sat    = (32'(tot_r) > 32'(TIME_MAX)) ? TIME_MAX : TIME_W'(tot_r);

  assign clearing  = (state_r == S_CLEAR);
  assign out_item  = out_r;
  assign out_empty = ~out_valid_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    road_we   = 1'b0;
    road_wa   = clr_addr_r;
    road_wd   = '0;
    road_ra   = road_key(u_r, i_idx);
    dist_we   = 1'b0;
    dist_wa   = pidx_r;
    dist_wd   = nd;
    dist_ra   = i_idx;
    pred_we   = 1'b0;
    path_we   = 1'b0;
    path_wa   = cnt_r[PB-1:0];
    path_wd   = walk_v_r;
    path_ra   = PB'(32'(cnt_r) - 32'd1 - 32'(k_r));
    emit      = 1'b0;
    emit_item = '0;
    case (state_r)
      S_CLEAR: begin
        road_we = 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            CMD_ADD: begin
              road_we   = 1'b1;
              road_wa   = q_key;
              road_wd   = {1'b0, WEIGHT_BITS'(q_cmd.w)};
              state_nxt = S_RESP;
            end
            CMD_BLOCK, CMD_UNBLOCK: begin
              road_ra   = q_key;
              state_nxt = S_RMW;
            end
            CMD_QUERY: begin
              dist_we   = 1'b1;
              dist_wa   = q_src;
              dist_wd   = '0;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_RMW: begin
        if (rw != '0) begin
          road_we = 1'b1;
          road_wa = road_key(NB'(cmd_r.a), NB'(cmd_r.b));
          road_wd = {(cmd_r.op == CMD_BLOCK), rw};
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_item.status = resp_r;
          emit_item.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sweep_done) begin
          if (!found_r) begin
            state_nxt = S_RESP;
          end else if (best_i_r == dst_r) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_RELAX;
          end
        end
      end
      S_RELAX: begin
        dist_we = relax_upd;
        pred_we = relax_upd;
        if (sweep_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_WALK: begin
        path_we = 1'b1;
        if (walk_end) begin
          path_wd   = src_r;
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: state_nxt = S_WALK;
      S_E_RD:      state_nxt = S_E_OUT;
      S_E_OUT: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_item.status     = ST_PATH;
          emit_item.node       = NODE_W'(path_rd_r);
          emit_item.total_time = tot_sat;
          emit_item.last       = e_last;
          state_nxt            = e_last ? S_IDLE : S_E_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (road_we) begin
      road_mem[road_wa] <= road_wd;
    end
    road_rd_r <= road_mem[road_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_r <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pidx_r] <= u_r;
    end
    pred_rd_r <= pred_mem[walk_v_r];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_wa] <= path_wd;
    end
    path_rd_r <= path_mem[path_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      reached_r   <= '0;
      fin_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == S_IDLE && !q_empty && q_cmd.op == CMD_QUERY) begin
        reached_r <= {{(NODES-1){1'b0}}, 1'b1} << q_src;
        fin_r     <= '0;
      end
      if (state_r == S_SCAN && sweep_done && found_r) begin
        fin_r[best_i_r] <= 1'b1;
      end
      if (state_r == S_RELAX && relax_upd) begin
        reached_r[pidx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_item;
    end
    if (state_r inside {S_SCAN, S_RELAX}) begin
      if (issue) begin
        idx_r  <= idx_r + IW'(1);
        pidx_r <= i_idx;
        pv_r   <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
    end
    case (state_r)
      S_IDLE: begin
        cmd_r   <= q_cmd;
        src_r   <= q_src;
        dst_r   <= NB'(q_cmd.b);
        idx_r   <= '0;
        pv_r    <= 1'b0;
        found_r <= 1'b0;
        case (q_cmd.op)
          CMD_ADD:     resp_r <= ST_ADDED;
          CMD_NO_PATH: resp_r <= ST_NO_PATH;
          default:     resp_r <= ST_NO_ROAD;
        endcase
      end
      S_RMW: resp_r <= (rw == '0) ? ST_NO_ROAD : ST_BLOCK_DONE;
      S_SCAN: begin
        if (cand) begin
          found_r  <= 1'b1;
          best_d_r <= dist_rd_r;
          best_i_r <= pidx_r;
        end
        if (sweep_done) begin
          idx_r    <= '0;
          u_r      <= best_i_r;
          du_r     <= best_d_r;
          tot_r    <= best_d_r;
          cnt_r    <= '0;
          walk_v_r <= dst_r;
          resp_r   <= ST_NO_PATH;
        end
      end
      S_RELAX: begin
        if (sweep_done) begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
      end
      S_WALK: begin
        cnt_r <= cnt_r + CW'(1);
        if (walk_end) begin
          k_r <= '0;
          n_r <= (32'(cnt_r) + 32'd1 > MAX_RES) ? RES_W'(MAX_RES)
                                                 : RES_W'(32'(cnt_r) + 32'd1);
        end
      end
      S_WALK_WAIT: walk_v_r <= pred_rd_r;
      S_E_OUT: begin
        if (slot_free && !e_last) begin
          k_r <= k_r + RES_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/blockable_road_shortest_path_core.sv
`timescale 1ns / 1ps
// Top level of the blockable road shortest-path core.
//
//  Channel   Ports                       Direction  Accepted when
//  input     in_push, in_full, in_item   in         in_push && !in_full
//  result    out_pop, out_empty, out_item out        out_pop && !out_empty
//
// Add road: one write of the road word. Block or unblock: read the road word, then write it.
// Query: per finalized node one scan pass and one relax pass over the road table port,
//   then the path walk from the destination back to the source, then the results.
// Reset: after rst_n the road table is swept to zero, one entry per cycle, over all
//   2**(2*ceil(log2 NODES)) entries (256 at NODES=16); in_full stays high meanwhile.
// Stalls: a two-entry command queue sits between the front and the sequencer, and
//   one result register parts the sequencer from out_pop.
module blockable_road_shortest_path_core #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  brsp_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output brsp_pkg::out_item_t out_item
);
  import brsp_pkg::*;

  // Front-to-queue and queue-to-back command path.
  cmd_t fq_cmd;
  cmd_t qb_cmd;
  logic fq_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic clearing;

  // Classify each item: range checks and weight masking happen here.
  brsp_front #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .in_item (in_item),
    .in_push (in_push),
    .in_full (in_full),
    .busy    (clearing),
    .q_full  (q_full),
    .q_push  (fq_push),
    .q_cmd   (fq_cmd)
  );

  // Hold up to two classified commands while the sequencer is busy.
  brsp_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (qb_cmd),
    .empty (q_empty)
  );

  // Execute commands against the road table and stream results.
  brsp_back #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (qb_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// File: rtl/brsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the road shortest-path core, bound to the top level.
module brsp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input brsp_pkg::in_item_t  in_item,
  input logic                out_pop,
  input logic                out_empty,
  input brsp_pkg::out_item_t out_item
);
  import brsp_pkg::*;

  // Reset leaves no result and holds off input for the table sweep.
  a_reset: assert property (@(posedge clk) !rst_n |=> (out_empty && in_full))
    else $error("reset did not clear results or block input");

  // Non-path answers are single, flagged last and carry no node or time.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.status != ST_PATH) |->
      (out_item.last && out_item.node == '0 && out_item.total_time == '0))
    else $error("non-path result malformed");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.status <= ST_NO_ROAD))
    else $error("undefined status code");

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule

bind blockable_road_shortest_path_core brsp_checker u_chk (.*);
